[hw/rtl/svs_pkg.sv]
// Shared types, constants and helpers for the two-bone vertex skinning block.
// Used by svs_front, svs_back and two_bone_vertex_skinning.
package svs_pkg;

  localparam int NUM_BONES     = 64;
  localparam int ROWS_PER_BONE = 4;
  localparam int COLS_PER_ROW  = 3;
  localparam int BONE_AW       = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
  localparam int ROW_W         = 32 * COLS_PER_ROW;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [16:0] ZERO_Q16 = 17'h00000;

  localparam logic OP_SKIN = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [5:0]         first_bone;
    logic [5:0]         second_bone;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic signed [31:0] val_c;
    logic [16:0]        blend_weight;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [63:0]        tex_coords;
    logic               last_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
    logic [63:0]        out_tex_coords;
    logic               last_out;
  } out_word_t;

  typedef struct packed {
    logic               is_write;
    logic [1:0]         row;
    logic [5:0]         bone_a;
    logic [5:0]         bone_b;
    logic               zero_a;
    logic               zero_b;
    logic [16:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [63:0]        tex;
    logic               last;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [50:0] hi;
    logic signed [50:0] lo;
    hi = 51'sh7FFFFFFF;
    lo = -51'sh80000000;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[hw/rtl/svs_front.sv]
// Front end: accepts input words, classifies them and queues commands.
// Depends on svs_pkg.
module svs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  svs_pkg::in_word_t in_word_i,
  output logic            cmd_valid_o,
  output svs_pkg::cmd_t   cmd_o,
  input  logic            cmd_pop_i
);
  import svs_pkg::*;

  cmd_t                cmd;
  cmd_t                q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                full, empty, push, bone_a_ok, bone_b_ok, row_ok;

  assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count_q == '0);
  assign in_stall_o  = full;
  assign cmd_valid_o = !empty;
  assign cmd_o       = q_mem[rd_ptr_q];

  assign bone_a_ok = 32'(in_word_i.first_bone) < NUM_BONES;
  assign bone_b_ok = 32'(in_word_i.second_bone) < NUM_BONES;
  assign row_ok    = 32'(in_word_i.second_bone) < ROWS_PER_BONE;

  always_comb begin
    cmd.is_write = (in_word_i.opcode == OP_ROW);
    cmd.row      = in_word_i.second_bone[1:0];
    cmd.bone_a   = in_word_i.first_bone;
    cmd.bone_b   = in_word_i.second_bone;
    cmd.zero_a   = !bone_a_ok;
    cmd.zero_b   = !bone_b_ok;
    if (in_word_i.first_bone == in_word_i.second_bone) begin
      cmd.weight = ZERO_Q16;
    end else if (in_word_i.blend_weight > ONE_Q16) begin
      cmd.weight = ONE_Q16;
    end else begin
      cmd.weight = in_word_i.blend_weight;
    end
    cmd.pos_x = in_word_i.val_a;
    cmd.pos_y = in_word_i.val_b;
    cmd.pos_z = in_word_i.val_c;
    cmd.nrm_x = in_word_i.normal_x;
    cmd.nrm_y = in_word_i.normal_y;
    cmd.nrm_z = in_word_i.normal_z;
    cmd.tex   = in_word_i.tex_coords;
    cmd.last  = in_word_i.last_vertex;
  end

  // drop row writes that fall outside the palette
  assign push = in_valid_i && !full &&
                ((in_word_i.opcode == OP_SKIN) || (bone_a_ok && row_ok));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i && !empty) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    count_d = count_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(cmd_pop_i && !empty);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |=> count_q <= 1)
    else $error("queue underflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

[hw/rtl/svs_back.sv]
// Back end: bone palette memory, per-bone transform and two-bone blend pipeline.
// Depends on svs_pkg; fed by svs_front.
module svs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  svs_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output svs_pkg::out_word_t out_word_o
);
  import svs_pkg::*;

  logic [ROW_W-1:0]   pal_mem [ROWS_PER_BONE][NUM_BONES];
  logic [ROW_W-1:0]   rd_q [2][ROWS_PER_BONE];
  logic [BONE_AW-1:0] idx_a, idx_b;
  logic               en;

  cmd_t               c1_q, c2_q, c3_q, c4_q;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;

  logic signed [31:0] vec [2][3];
  logic signed [31:0] mat [2][ROWS_PER_BONE][3];
  logic signed [47:0] prod_q [2][2][3][3];
  logic signed [31:0] t_q [2][3];
  logic signed [31:0] xf_q [2][2][3];
  logic signed [49:0] bl_q [2][3][2];
  out_word_t          out_q;

  assign en        = !(v5_q && out_stall_i);
  assign cmd_pop_o = en && cmd_valid_i;
  assign idx_a     = BONE_AW'(cmd_i.bone_a);
  assign idx_b     = BONE_AW'(cmd_i.bone_b);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.is_write) begin
      pal_mem[cmd_i.row][idx_a] <= {cmd_i.pos_z, cmd_i.pos_y, cmd_i.pos_x};
    end
    if (en) begin
      for (int r = 0; r < ROWS_PER_BONE; r++) begin
        rd_q[0][r] <= pal_mem[r][idx_a];
        rd_q[1][r] <= pal_mem[r][idx_b];
      end
    end
  end

  always_comb begin
    vec[0][0] = c1_q.pos_x;
    vec[0][1] = c1_q.pos_y;
    vec[0][2] = c1_q.pos_z;
    vec[1][0] = c1_q.nrm_x;
    vec[1][1] = c1_q.nrm_y;
    vec[1][2] = c1_q.nrm_z;
    for (int b = 0; b < 2; b++) begin
      for (int r = 0; r < ROWS_PER_BONE; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat[b][r][c] = ((b == 0) ? c1_q.zero_a : c1_q.zero_b) ? 32'sd0 :
                         $signed(rd_q[b][r][32*c +: 32]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      for (int b = 0; b < 2; b++) begin
        for (int k = 0; k < 2; k++) begin
          for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
              prod_q[b][k][c][r] <= 48'((64'(vec[k][r]) * 64'(mat[b][r][c])) >>> 16);
            end
          end
        end
        for (int c = 0; c < 3; c++) begin
          t_q[b][c] <= mat[b][3][c];
        end
      end
      for (int b = 0; b < 2; b++) begin
        for (int k = 0; k < 2; k++) begin
          for (int c = 0; c < 3; c++) begin
            xf_q[b][k][c] <= sat32(51'(prod_q[b][k][c][0]) + 51'(prod_q[b][k][c][1]) +
                                   51'(prod_q[b][k][c][2]) +
                                   ((k == 0) ? 51'(t_q[b][c]) : 51'sd0));
          end
        end
      end
      for (int k = 0; k < 2; k++) begin
        for (int c = 0; c < 3; c++) begin
          bl_q[k][c][0] <= 50'($signed({1'b0, ONE_Q16 - c3_q.weight}) * 50'(xf_q[0][k][c]));
          bl_q[k][c][1] <= 50'($signed({1'b0, c3_q.weight}) * 50'(xf_q[1][k][c]));
        end
      end
      out_q.out_pos_x  <= sat32((51'(bl_q[0][0][0]) + 51'(bl_q[0][0][1])) >>> 16);
      out_q.out_pos_y  <= sat32((51'(bl_q[0][1][0]) + 51'(bl_q[0][1][1])) >>> 16);
      out_q.out_pos_z  <= sat32((51'(bl_q[0][2][0]) + 51'(bl_q[0][2][1])) >>> 16);
      out_q.out_norm_x <= sat32((51'(bl_q[1][0][0]) + 51'(bl_q[1][0][1])) >>> 16);
      out_q.out_norm_y <= sat32((51'(bl_q[1][1][0]) + 51'(bl_q[1][1][1])) >>> 16);
      out_q.out_norm_z <= sat32((51'(bl_q[1][2][0]) + 51'(bl_q[1][2][1])) >>> 16);
      out_q.out_tex_coords <= c4_q.tex;
      out_q.last_out       <= c4_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= cmd_valid_i && !cmd_i.is_write;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_word_o  = out_q;

endmodule

[hw/rtl/two_bone_vertex_skinning.sv]
// Two-bone linear blend skinning, top level.
// Instantiates svs_front and svs_back; depends on svs_pkg.
//
// Input channel in_valid_i / in_stall_o / in_word_i carries one word per
// vertex (opcode skin) or per palette row write (opcode row). A row write
// produces no output word; each vertex produces exactly one output word on
// out_valid_o / out_stall_i / out_word_o, in input order.
// Throughput: one word per clock while the output is not stalled.
// The accepting edge writes the four-entry command queue; the word
// then passes the registered palette read, product, per-bone sum,
// blend product and blend sum, the last of which is the output register.
// A row write is visible to every vertex accepted after it.
// When the receiver stalls a valid output word, the back pipeline holds;
// the queue fills and in_stall_o rises once it is full.
// Reset clears the queue and the pipeline valid bits. The palette is not
// cleared: every palette row a vertex uses must be written after reset
// before that vertex is sent.
module two_bone_vertex_skinning (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  svs_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output svs_pkg::out_word_t  out_word_o
);
  import svs_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  svs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  svs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
